>>> sv/fat12_cluster_chain_walker_top_macros.svh
// Assertion macros shared by the checker of the FAT12 cluster chain walker.
// Depends on nothing; the including scope provides clk and rst_n.
`ifndef FAT12_CLUSTER_CHAIN_WALKER_TOP_MACROS_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_TOP_MACROS_SVH

// General property checked on every rising edge outside reset.
`define FCW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A stalled valid/ready channel keeps the given signal stable.
`define FCW_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

>>> sv/fcw_pkg.sv
// Package of the FAT12 cluster chain walker: codes, defaults, shared types.
// Depends on nothing; the modules and the checker use it by scoped names.
package fcw_pkg;

    localparam int FAT_BYTES_DEF    = 8192;
    localparam int SECTOR_BYTES_DEF = 512;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_BEGIN   = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    localparam logic [15:0] OFFSET_RESET = 16'd31;
    localparam logic [11:0] END_RESET    = 12'hFF8;

    localparam int PADDR_W = 3;
    localparam logic CFG_IDX_OFFSET = 1'b0;
    localparam logic CFG_IDX_END    = 1'b1;

    localparam logic [9:0] COUNT_MAX = 10'd1023;

    typedef struct packed {
        logic        wr_en;
        logic [12:0] wr_addr;
        logic [7:0]  wr_data;
        logic        rd_en;
        logic [12:0] rd_base;
    } fat_req_t;

    // Unpacks a 12-bit entry from the two bytes that hold it.
    function automatic logic [11:0] unpack_entry(input logic odd, input logic [7:0] lo,
                                                 input logic [7:0] hi);
        logic [11:0] entry;
        if (odd)
            entry = {hi, lo[7:4]};
        else
            entry = {hi[3:0], lo};
        return entry;
    endfunction

endpackage

>>> sv/fcw_if.sv
// Valid/ready channel interfaces for the input items and result items.
// Depends on nothing but plain logic types.
interface fcw_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [12:0] fat_address;
    logic [7:0]  fat_byte;
    logic [11:0] start_cluster;
    logic [31:0] size_bytes;

    modport source (output valid, op, fat_address, fat_byte, start_cluster, size_bytes,
                    input ready);
    modport sink (input valid, op, fat_address, fat_byte, start_cluster, size_bytes,
                  output ready);
endinterface

interface fcw_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] sector;
    logic [9:0]  byte_count;
    logic [11:0] next_cluster;
    logic        last;

    modport source (output valid, sector, byte_count, next_cluster, last, input ready);
    modport sink (input valid, sector, byte_count, next_cluster, last, output ready);
endinterface

>>> sv/fcw_fat_mem.sv
// FAT byte store split into an even and an odd bank so both entry bytes read at once.
// Depends on fcw_pkg for the request struct.
module fcw_fat_mem #(
    parameter int FAT_BYTES = fcw_pkg::FAT_BYTES_DEF
) (
    input  logic             clk,
    input  fcw_pkg::fat_req_t req,
    output logic [7:0]       lo_byte,
    output logic [7:0]       hi_byte
);

    localparam int BANK_DEPTH = (FAT_BYTES + 1) / 2;
    localparam int BIW        = $clog2(BANK_DEPTH);

    logic [7:0] even_mem [BANK_DEPTH];
    logic [7:0] odd_mem  [BANK_DEPTH];

    logic [13:0]    base1;
    logic           wr_ok;
    logic           lo_ok;
    logic           hi_ok;
    logic [BIW-1:0] wr_idx;
    logic [BIW-1:0] even_idx;
    logic [BIW-1:0] odd_idx;

    logic [7:0] even_q_reg;
    logic [7:0] odd_q_reg;
    logic       sel_odd_reg;
    logic       lo_ok_reg;
    logic       hi_ok_reg;

    assign base1    = {1'b0, req.rd_base} + 14'd1;
    assign wr_ok    = {1'b0, req.wr_addr} < 14'(FAT_BYTES);
    assign lo_ok    = {1'b0, req.rd_base} < 14'(FAT_BYTES);
    assign hi_ok    = base1 < 14'(FAT_BYTES);
    assign wr_idx   = req.wr_addr[BIW:1];
    // The odd byte of the pair always sits at base/2; the even one at (base+1)/2.
    assign odd_idx  = req.rd_base[BIW:1];
    assign even_idx = base1[BIW:1];

    always_ff @(posedge clk)
    begin
        if (req.wr_en && wr_ok && !req.wr_addr[0])
            even_mem[wr_idx] <= req.wr_data;
        if (req.wr_en && wr_ok && req.wr_addr[0])
            odd_mem[wr_idx] <= req.wr_data;
        if (req.rd_en)
        begin
            even_q_reg  <= even_mem[even_idx];
            odd_q_reg   <= odd_mem[odd_idx];
            sel_odd_reg <= req.rd_base[0];
            lo_ok_reg   <= lo_ok;
            hi_ok_reg   <= hi_ok;
        end
    end

    assign lo_byte = !lo_ok_reg ? 8'd0 : (sel_odd_reg ? odd_q_reg : even_q_reg);
    assign hi_byte = !hi_ok_reg ? 8'd0 : (sel_odd_reg ? even_q_reg : odd_q_reg);

endmodule

>>> sv/fcw_ctrl.sv
// Chain sequencer: decodes items, issues FAT reads and holds the result register.
// Depends on fcw_pkg and the channel interfaces in fcw_if.sv.
module fcw_ctrl #(
    parameter int SECTOR_BYTES = fcw_pkg::SECTOR_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    fcw_in_if.sink            in_ch,
    fcw_out_if.source         out_ch,
    input  logic [15:0]       data_sector_offset,
    input  logic [11:0]       end_marker,
    output fcw_pkg::fat_req_t req,
    input  logic [7:0]        lo_byte,
    input  logic [7:0]        hi_byte
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;
    localparam logic [31:0] SB = 32'(SECTOR_BYTES);

    logic        state_reg, state_next;
    logic [11:0] cur_reg, cur_next;
    logic [31:0] rem_reg, rem_next;
    logic        active_reg, active_next;
    logic        out_valid_reg, out_valid_next;
    logic [16:0] sector_reg;
    logic [9:0]  count_reg;
    logic [11:0] next_cl_reg;
    logic        last_reg;

    logic        accept;
    logic        finish;
    logic [13:0] triple;
    logic [11:0] entry;
    logic        entry_last;
    logic [31:0] count_wide;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign finish      = (state_reg == S_READ) && (!out_valid_reg || out_ch.ready);

    // Entry of cluster n starts at byte 3n/2.
    assign triple     = {2'b00, cur_reg} + {1'b0, cur_reg, 1'b0};
    assign entry      = fcw_pkg::unpack_entry(cur_reg[0], lo_byte, hi_byte);
    assign entry_last = entry >= end_marker;
    assign count_wide = (rem_reg < SB) ? rem_reg : SB;

    always_comb
    begin
        req.wr_en   = accept && (in_ch.op == fcw_pkg::OP_LOAD);
        req.wr_addr = in_ch.fat_address;
        req.wr_data = in_ch.fat_byte;
        req.rd_en   = accept && (in_ch.op == fcw_pkg::OP_ADVANCE) && active_reg;
        req.rd_base = triple[13:1];
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        rem_next       = rem_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_ch.op == fcw_pkg::OP_BEGIN)
                begin
                    cur_next    = in_ch.start_cluster;
                    rem_next    = in_ch.size_bytes;
                    active_next = in_ch.start_cluster < end_marker;
                end
                if (req.rd_en)
                    state_next = S_READ;
            end
            S_READ:
            begin
                if (finish)
                begin
                    out_valid_next = 1'b1;
                    cur_next       = entry;
                    rem_next       = (rem_reg > SB) ? rem_reg - SB : 32'd0;
                    active_next    = !entry_last;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= 12'd0;
            rem_reg       <= 32'd0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            rem_reg       <= rem_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            sector_reg  <= {5'd0, cur_reg} + {1'b0, data_sector_offset};
            count_reg   <= (count_wide > 32'(fcw_pkg::COUNT_MAX)) ? fcw_pkg::COUNT_MAX
                                                                  : count_wide[9:0];
            next_cl_reg <= entry;
            last_reg    <= entry_last;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.sector       = sector_reg;
    assign out_ch.byte_count   = count_reg;
    assign out_ch.next_cluster = next_cl_reg;
    assign out_ch.last         = last_reg;

endmodule

>>> sv/fat12_cluster_chain_walker_top.sv
// Top level of the FAT12 cluster chain walker: APB registers, sequencer, FAT store.
// Depends on fcw_pkg, fcw_if.sv, fcw_fat_mem and fcw_ctrl.
//
// The block keeps a FAT12 allocation table in an on-chip byte store and follows
// one file's cluster chain through it. Input items arrive on in_ch: a load item
// writes one table byte, a begin item sets the start cluster and file size, and
// an advance item yields one result item on out_ch with the data sector, the
// byte count for that sector and the next cluster. Once a chain reaches the end
// marker, advance items are dropped until the next begin item.
// Load, begin and dropped items finish as they are accepted. An advance also passes
// a read state: the store is split into even and odd banks so both entry bytes come
// out of one synchronous read, and the entry is unpacked in the cycle after that read.
// The result lands in an output register at the end of the read state, and the next
// item is taken while that result still waits.
// If out_ch stalls with a result pending, a following advance waits after its
// read until the register drains; loads and begins flow only up to that advance.
// Reset clears the chain state and restores data_sector_offset to 31 and
// end_marker to 0xFF8. The table contents are not cleared and must be loaded.
// Registers sit at byte addresses 0 (data_sector_offset) and 4 (end_marker).
module fat12_cluster_chain_walker_top #(
    parameter int FAT_BYTES    = fcw_pkg::FAT_BYTES_DEF,
    parameter int SECTOR_BYTES = fcw_pkg::SECTOR_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    fcw_in_if.sink                     in_ch,
    fcw_out_if.source                  out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fcw_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [15:0]       offset_reg;
    logic [11:0]       end_marker_reg;
    logic              cfg_write;
    fcw_pkg::fat_req_t req;
    logic [7:0]        lo_byte;
    logic [7:0]        hi_byte;

    // Registers are decoded on the word index alone; the byte lane bits are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= fcw_pkg::OFFSET_RESET;
            end_marker_reg <= fcw_pkg::END_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == fcw_pkg::CFG_IDX_OFFSET)
                offset_reg <= pwdata[15:0];
            else
                end_marker_reg <= pwdata[11:0];
        end
    end

    assign prdata = (paddr[2] == fcw_pkg::CFG_IDX_END) ? {20'd0, end_marker_reg}
                                                        : {16'd0, offset_reg};

    fcw_ctrl #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_ctrl (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_ch              (in_ch),
        .out_ch             (out_ch),
        .data_sector_offset (offset_reg),
        .end_marker         (end_marker_reg),
        .req                (req),
        .lo_byte            (lo_byte),
        .hi_byte            (hi_byte)
    );

    fcw_fat_mem #(
        .FAT_BYTES (FAT_BYTES)
    ) u_fat_mem (
        .clk     (clk),
        .req     (req),
        .lo_byte (lo_byte),
        .hi_byte (hi_byte)
    );

endmodule

>>> sv/fcw_checker.sv
// Port-level checker for the FAT12 cluster chain walker, bound to the top level.
// Depends on fcw_pkg and fat12_cluster_chain_walker_top_macros.svh.
`include "fat12_cluster_chain_walker_top_macros.svh"

module fcw_checker #(
    parameter int SECTOR_BYTES = fcw_pkg::SECTOR_BYTES_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [16:0] sector,
    input logic [9:0]  byte_count,
    input logic [11:0] next_cluster,
    input logic        last
);

    localparam logic [9:0] COUNT_LIMIT = (SECTOR_BYTES > 1023) ? fcw_pkg::COUNT_MAX
                                                               : 10'(SECTOR_BYTES);

    logic [39:0] payload;

    assign payload = {sector, byte_count, next_cluster, last};

    `FCW_ASSERT_HOLD(a_out_valid_hold, out_valid, out_ready, out_valid, "result dropped")
    `FCW_ASSERT_HOLD(a_out_payload_hold, out_valid, out_ready, payload, "result changed")
    // A new result only appears after the read cycle, during which input is held off.
    `FCW_ASSERT(a_result_after_read, $rose(out_valid) |-> !$past(in_ready), "no read cycle")
    `FCW_ASSERT(a_count_limit, out_valid |-> (byte_count <= COUNT_LIMIT), "count too big")

endmodule

bind fat12_cluster_chain_walker_top fcw_checker #(
    .SECTOR_BYTES (SECTOR_BYTES)
) u_fcw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .sector       (out_ch.sector),
    .byte_count   (out_ch.byte_count),
    .next_cluster (out_ch.next_cluster),
    .last         (out_ch.last)
);
